@@ rtl/core/hcde_pkg.sv @@
package hcde_pkg;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_STEP = 2'd1,
		OP_SET  = 2'd2,
		OP_LOAD = 2'd3
	} op_t;

	// Digit positions selected by the cursor.
	typedef enum logic [1:0] {
		CUR_HOUR_TENS   = 2'd0,
		CUR_HOUR_UNITS  = 2'd1,
		CUR_MINUTE_TENS = 2'd2,
		CUR_MINUTE_UNITS = 2'd3
	} cursor_t;

	// Step direction codes. The ignored code (-2) means the step changes nothing.
	localparam logic signed [1:0] DIR_NONE    = 2'sb00;
	localparam logic signed [1:0] DIR_UP      = 2'sb01;
	localparam logic signed [1:0] DIR_DOWN    = 2'sb11;
	localparam logic signed [1:0] DIR_IGNORED = 2'sb10;

	localparam int unsigned TIME_W    = 14;
	localparam int unsigned ALARM_W   = 12;
	localparam int unsigned HOUR_W    = 7;
	localparam int unsigned AHOUR_W   = 6;
	localparam int unsigned DIFF_W    = 14;

	localparam logic [3:0] DIGIT_MAX  = 4'd9;
	localparam logic [3:0] DIGIT_BASE = 4'd10;
	localparam logic [3:0] HT_BASE    = 4'd3;
	localparam logic [3:0] MT_BASE    = 4'd6;

	// Division by 100 of a 12-bit value: (x * 5243) >> 19 is exact over the range.
	localparam logic [12:0] Div100Mul   = 13'd5243;
	localparam int unsigned Div100Shift = 19;
	localparam logic [6:0]  DecHundred  = 7'd100;

	// The time of day held as four decimal digits.
	typedef struct packed {
		logic [3:0] ht;
		logic [3:0] hu;
		logic [3:0] mt;
		logic [3:0] mu;
	} time_digits_t;

	// True when hour*100+minute is at most 23:59.
	function automatic logic time_ok(input time_digits_t t);
		return (t.ht < 4'd2) ||
			((t.ht == 4'd2) && ((t.hu < 4'd3) || ((t.hu == 4'd3) && (t.mt <= 4'd5))));
	endfunction

	// Moves a digit by -1, 0 or +1 and reduces it modulo the given base; the value
	// below zero maps to the fallback. The sum stays below twice the base here.
	function automatic logic [3:0] wrap_digit(input logic [3:0] d,
			input logic signed [1:0] dir, input logic [3:0] base,
			input logic [3:0] fallback);
		logic signed [5:0] x;
		x = $signed({2'b00, d}) + 6'(dir);
		if (x[5])
			return fallback;
		else if (x[4:0] >= {1'b0, base})
			return 4'(x[4:0] - {1'b0, base});
		else
			return x[3:0];
	endfunction

	// Splits a value of up to 63 into decimal tens and units.
	function automatic logic [7:0] split_decimal(input logic [5:0] x);
		logic [3:0] tens;
		logic [6:0] rem;
		tens = 4'd0;
		for (int k = 1; k <= 6; k++) begin
			if (x >= 6'(10 * k))
				tens = 4'(k);
		end
		rem = 7'(x) - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
		return {tens, rem[3:0]};
	endfunction

	// Two decimal digits to their binary value.
	function automatic logic [6:0] join_decimal(input logic [3:0] tens,
			input logic [3:0] units);
		return 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(units);
	endfunction

endpackage

@@ rtl/core/hhmm_clock_digit_editor.sv @@
// Decimal HH:MM clock with digit editing and an alarm compare. Each item is one
// operation on the stored time (tick one minute, step one digit under the cursor,
// set one digit, or load an hour and a minute), and each item gives exactly one
// result: the new hour and minute, whether the time is at most 23:59, whether it
// equals the alarm, and the minutes until the alarm (-1 when the alarm lies
// earlier). The block takes one item every clock cycle unless out_stall has filled
// every stage, and returns its result through an input register, the time update,
// which writes the stored time so the next item sees it at once, and the result
// register that holds the alarm compare and the minute difference. Each stage
// moves on its own, so an empty stage keeps taking items while a finished result
// waits under out_stall. The time is kept as four decimal digits and resets to
// 00:00. The user must write the alarm through cfg_wr_en and cfg_wr_data while no
// item is in flight (unenforced); it is split into hour and minute at the write.
module hhmm_clock_digit_editor
	import hcde_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_wr_en,
	input  logic [ALARM_W-1:0]         cfg_wr_data,

	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [1:0]                 cursor,
	input  logic signed [1:0]          direction,
	input  logic [3:0]                 digit_value,
	input  logic [4:0]                 load_hour,
	input  logic [5:0]                 load_minute,

	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [HOUR_W-1:0]          hour,
	output logic [HOUR_W-1:0]          minute,
	output logic                       time_valid,
	output logic                       alarm_match,
	output logic signed [DIFF_W-1:0]   minutes_to_alarm
);

	// Stage enables. A stage may load when it is empty or when its content moves on.
	logic en1, en2, en3;

	// Input register.
	logic                valid_s1;
	op_t                 op_s1;
	cursor_t             cursor_s1;
	logic signed [1:0]   dir_s1;
	logic [3:0]          digit_s1;
	logic [4:0]          load_hour_s1;
	logic [5:0]          load_minute_s1;

	// Stored time and its next value.
	time_digits_t        time_q;
	time_digits_t        time_next;
	time_digits_t        tick_t;
	time_digits_t        step_t;
	time_digits_t        set_t;
	logic                tick_carry;
	logic                tick_over;

	// Time stage results.
	logic                valid_s2;
	logic [HOUR_W-1:0]   hour_s2;
	logic [HOUR_W-1:0]   minute_s2;
	logic                time_ok_s2;

	// Alarm split into hour and minute.
	logic [AHOUR_W-1:0]  alarm_hour_q;
	logic [HOUR_W-1:0]   alarm_minute_q;
	logic [24:0]         alarm_prod;
	logic [AHOUR_W-1:0]  alarm_hour_d;
	logic [ALARM_W-1:0]  alarm_rem;

	// Compare and difference.
	logic                alarm_before;
	logic                alarm_eq;
	logic signed [8:0]   hour_diff;
	logic signed [8:0]   minute_diff;
	logic signed [15:0]  hour_diff_x;
	logic signed [15:0]  diff_sum;

	// Result register.
	logic                valid_s3;
	logic [HOUR_W-1:0]   hour_s3;
	logic [HOUR_W-1:0]   minute_s3;
	logic                time_ok_s3;
	logic                alarm_match_s3;
	logic signed [DIFF_W-1:0] diff_s3;

	assign en3 = !valid_s3 || !out_stall;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_stall = !en1;

	// ---------------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			op_s1          <= op_t'(operation);
			cursor_s1      <= cursor_t'(cursor);
			dir_s1         <= direction;
			digit_s1       <= digit_value;
			load_hour_s1   <= load_hour;
			load_minute_s1 <= load_minute;
		end
	end

	// ---------------------------------------------------------------- alarm register
	// The quotient by 100 comes from a reciprocal multiply; the remainder is what
	// is left after taking the quotient times 100 back off.
	assign alarm_prod   = 25'(cfg_wr_data) * 25'(Div100Mul);
	assign alarm_hour_d = alarm_prod[Div100Shift +: AHOUR_W];
	assign alarm_rem    = cfg_wr_data - 12'(alarm_hour_d) * 12'(DecHundred);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_hour_q   <= '0;
			alarm_minute_q <= '0;
		end else if (cfg_wr_en) begin
			alarm_hour_q   <= alarm_hour_d;
			alarm_minute_q <= alarm_rem[HOUR_W-1:0];
		end
	end

	// ---------------------------------------------------------------- time update
	// Tick: minute 59 rolls over to 00 with a carry, and so does minute 99. The
	// hour then counts up; hour 24 wraps to 00, and a carry out of hour 99 takes
	// the whole time back to 00:00.
	always_comb begin
		tick_t     = time_q;
		tick_carry = ((time_q.mt == 4'd5) || (time_q.mt == DIGIT_MAX)) &&
			(time_q.mu == DIGIT_MAX);
		tick_over  = tick_carry && (time_q.ht == DIGIT_MAX) && (time_q.hu == DIGIT_MAX);
		if (tick_carry) begin
			tick_t.mt = 4'd0;
			tick_t.mu = 4'd0;
			if (time_q.hu == DIGIT_MAX) begin
				tick_t.hu = 4'd0;
				tick_t.ht = time_q.ht + 4'd1;
			end else begin
				tick_t.hu = time_q.hu + 4'd1;
			end
		end else if (time_q.mu == DIGIT_MAX) begin
			tick_t.mu = 4'd0;
			tick_t.mt = time_q.mt + 4'd1;
		end else begin
			tick_t.mu = time_q.mu + 4'd1;
		end
		if (tick_over || ((tick_t.ht == 4'd2) && (tick_t.hu == 4'd4))) begin
			tick_t.ht = 4'd0;
			tick_t.hu = 4'd0;
		end
	end

	// Step: only on a valid time and a known direction. Each digit wraps under its
	// own base; the hour units digit runs 0 to 3 while the hour tens digit is 2.
	always_comb begin
		step_t = time_q;
		if (time_ok(time_q) && (dir_s1 != DIR_IGNORED)) begin
			case (cursor_s1)
				CUR_HOUR_TENS: begin
					step_t.ht = wrap_digit(time_q.ht, dir_s1, HT_BASE, 4'd2);
					if (!time_ok(step_t))
						step_t.hu = 4'd3;
				end
				CUR_HOUR_UNITS: begin
					case (dir_s1)
						DIR_UP: begin
							if (time_q.ht == 4'd2)
								step_t.hu = {2'b00, 2'(time_q.hu + 4'd1)};
							else
								step_t.hu = (time_q.hu == DIGIT_MAX) ? 4'd0 : time_q.hu + 4'd1;
						end
						DIR_DOWN: begin
							if (time_q.hu == 4'd0)
								step_t.hu = (time_q.ht == 4'd2) ? 4'd3 : DIGIT_MAX;
							else
								step_t.hu = time_q.hu - 4'd1;
						end
						default: step_t.hu = time_q.hu;
					endcase
				end
				CUR_MINUTE_TENS: begin
					step_t.mt = wrap_digit(time_q.mt, dir_s1, MT_BASE, 4'd5);
				end
				CUR_MINUTE_UNITS: begin
					step_t.mu = wrap_digit(time_q.mu, dir_s1, DIGIT_BASE, DIGIT_MAX);
				end
				default: step_t = time_q;
			endcase
		end
	end

	// Set: a digit of 10 or more leaves the time alone.
	always_comb begin
		set_t = time_q;
		if (digit_s1 < DIGIT_BASE) begin
			case (cursor_s1)
				CUR_HOUR_TENS:    set_t.ht = digit_s1;
				CUR_HOUR_UNITS:   set_t.hu = digit_s1;
				CUR_MINUTE_TENS:  set_t.mt = digit_s1;
				CUR_MINUTE_UNITS: set_t.mu = digit_s1;
				default:          set_t = time_q;
			endcase
		end
	end

	always_comb begin
		case (op_s1)
			OP_TICK: time_next = tick_t;
			OP_STEP: time_next = step_t;
			OP_SET:  time_next = set_t;
			OP_LOAD: time_next = {split_decimal({1'b0, load_hour_s1}),
				split_decimal(load_minute_s1)};
			default: time_next = time_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				time_q <= time_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			hour_s2    <= join_decimal(time_next.ht, time_next.hu);
			minute_s2  <= join_decimal(time_next.mt, time_next.mu);
			time_ok_s2 <= time_ok(time_next);
		end
	end

	// ---------------------------------------------------------------- result stage
	// Minutes stay below 100 on both sides, so comparing hour first and minute
	// second orders the values exactly as hour*100+minute would.
	assign alarm_eq     = ({1'b0, alarm_hour_q} == hour_s2) && (alarm_minute_q == minute_s2);
	assign alarm_before = ({1'b0, alarm_hour_q} < hour_s2) ||
		(({1'b0, alarm_hour_q} == hour_s2) && (alarm_minute_q < minute_s2));

	assign hour_diff   = $signed({3'b000, alarm_hour_q}) - $signed({2'b00, hour_s2});
	assign minute_diff = $signed({2'b00, alarm_minute_q}) - $signed({2'b00, minute_s2});
	assign hour_diff_x = 16'(hour_diff);
	// Times 60 as times 64 less times 4.
	assign diff_sum    = (hour_diff_x <<< 6) - (hour_diff_x <<< 2) + 16'(minute_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			hour_s3        <= hour_s2;
			minute_s3      <= minute_s2;
			time_ok_s3     <= time_ok_s2;
			alarm_match_s3 <= alarm_eq;
			diff_s3        <= alarm_before ? -14'sd1 : diff_sum[DIFF_W-1:0];
		end
	end

	assign out_valid        = valid_s3;
	assign hour             = hour_s3;
	assign minute           = minute_s3;
	assign time_valid       = time_ok_s3;
	assign alarm_match      = alarm_match_s3;
	assign minutes_to_alarm = diff_s3;

	// ---------------------------------------------------------------- assertions
	// The stored time always stays a four-digit decimal value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(time_q.ht <= DIGIT_MAX) && (time_q.hu <= DIGIT_MAX) &&
		(time_q.mt <= DIGIT_MAX) && (time_q.mu <= DIGIT_MAX))
		else $error("stored time digit out of decimal range");

	// A valid time never shows an hour past 23.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && time_valid) |-> (hour <= 7'd23))
		else $error("valid time with hour past 23");

	// A match with the alarm means no minutes remain.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && alarm_match) |-> (minutes_to_alarm == 14'sd0))
		else $error("alarm match with nonzero minutes to alarm");

	// The input side holds off only when every stage is full and the output is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule
